// File: sv/lsfp_pkg.sv
// Shared types and constants for the scanner frame parser.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package lsfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam int ANGLE_SLOTS_DEF = 360;

  localparam logic [13:0] MIN_DIST_RST = 14'd50;
  localparam logic [13:0] MAX_DIST_RST = 14'd4000;

  // register indexes on the configuration port
  localparam logic REG_MIN_DIST = 1'b0;
  localparam logic REG_MAX_DIST = 1'b1;

  localparam int BYTE_W  = 8;
  localparam int ANGLE_W = 9;
  localparam int DIST_W  = 14;
  localparam int PROD_W  = BYTE_W + ANGLE_W;
  localparam int CNT_W   = $clog2(PROD_W);

  typedef enum logic [3:0] {
    PH_HUNT_A,
    PH_HUNT_B,
    PH_TYPE,
    PH_COUNT,
    PH_FSA_LO,
    PH_FSA_HI,
    PH_LSA_LO,
    PH_LSA_HI,
    PH_CS_LO,
    PH_CS_HI,
    PH_SMP_LO,
    PH_SMP_HI,
    PH_MUL,
    PH_DIV,
    PH_EMIT
  } phase_t;

  typedef struct packed {
    logic ld_count;
    logic ld_low;
    logic ld_start;
    logic ld_span;
    logic ld_sample;
    logic mul;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_sync_first;
    logic is_sync_second;
    logic total_zero;
    logic div_last;
    logic last;
    logic out_busy;
  } status_t;

endpackage

// File: sv/lsfp_ctrl.sv
// Frame parsing state machine: walks sync, header and sample bytes and
// sequences the multiply and divide for each sample. Depends on lsfp_pkg.
`timescale 1ns / 1ps

module lsfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsfp_pkg::status_t st,
  output lsfp_pkg::cmd_t    cmd
);

  lsfp_pkg::phase_t state_r, state_nxt;
  logic acc;

  // words are taken only in the parsing phases
  assign in_stall = state_r inside {lsfp_pkg::PH_MUL, lsfp_pkg::PH_DIV, lsfp_pkg::PH_EMIT};
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsfp_pkg::PH_HUNT_A;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      lsfp_pkg::PH_HUNT_A: begin
        if (acc && st.is_sync_first) state_nxt = lsfp_pkg::PH_HUNT_B;
      end
      lsfp_pkg::PH_HUNT_B: begin
        // a repeated first sync byte keeps waiting for the second
        if (acc) begin
          if (st.is_sync_second) state_nxt = lsfp_pkg::PH_TYPE;
          else if (!st.is_sync_first) state_nxt = lsfp_pkg::PH_HUNT_A;
        end
      end
      lsfp_pkg::PH_TYPE: begin
        if (acc) state_nxt = lsfp_pkg::PH_COUNT;
      end
      lsfp_pkg::PH_COUNT: begin
        if (acc) begin
          cmd.ld_count = 1'b1;
          state_nxt = lsfp_pkg::PH_FSA_LO;
        end
      end
      lsfp_pkg::PH_FSA_LO: begin
        if (acc) begin
          cmd.ld_low = 1'b1;
          state_nxt = lsfp_pkg::PH_FSA_HI;
        end
      end
      lsfp_pkg::PH_FSA_HI: begin
        if (acc) begin
          cmd.ld_start = 1'b1;
          state_nxt = lsfp_pkg::PH_LSA_LO;
        end
      end
      lsfp_pkg::PH_LSA_LO: begin
        if (acc) begin
          cmd.ld_low = 1'b1;
          state_nxt = lsfp_pkg::PH_LSA_HI;
        end
      end
      lsfp_pkg::PH_LSA_HI: begin
        if (acc) begin
          cmd.ld_span = 1'b1;
          state_nxt = lsfp_pkg::PH_CS_LO;
        end
      end
      lsfp_pkg::PH_CS_LO: begin
        if (acc) state_nxt = lsfp_pkg::PH_CS_HI;
      end
      lsfp_pkg::PH_CS_HI: begin
        if (acc) state_nxt = st.total_zero ? lsfp_pkg::PH_HUNT_A : lsfp_pkg::PH_SMP_LO;
      end
      lsfp_pkg::PH_SMP_LO: begin
        if (acc) begin
          cmd.ld_low = 1'b1;
          state_nxt = lsfp_pkg::PH_SMP_HI;
        end
      end
      lsfp_pkg::PH_SMP_HI: begin
        if (acc) begin
          cmd.ld_sample = 1'b1;
          state_nxt = lsfp_pkg::PH_MUL;
        end
      end
      lsfp_pkg::PH_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = lsfp_pkg::PH_DIV;
      end
      lsfp_pkg::PH_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = lsfp_pkg::PH_EMIT;
      end
      lsfp_pkg::PH_EMIT: begin
        // hold until the output register is free
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = st.last ? lsfp_pkg::PH_HUNT_A : lsfp_pkg::PH_SMP_LO;
        end
      end
      default: begin
        state_nxt = lsfp_pkg::PH_HUNT_A;
      end
    endcase
  end

endmodule

// File: sv/lsfp_dp.sv
// Datapath: header and sample registers, index*span multiplier, restoring
// divider and the output register. Depends on lsfp_pkg.
`timescale 1ns / 1ps

module lsfp_dp #(
  parameter int ANGLE_SLOTS = lsfp_pkg::ANGLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lsfp_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [lsfp_pkg::DIST_W-1:0]   min_dist,
  input  logic [lsfp_pkg::DIST_W-1:0]   max_dist,
  input  lsfp_pkg::cmd_t                cmd,
  output lsfp_pkg::status_t             st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsfp_pkg::ANGLE_W-1:0]  out_angle_deg,
  output logic [lsfp_pkg::DIST_W-1:0]   out_distance_mm,
  output logic                          out_last_in_frame
);

  localparam int BW = lsfp_pkg::BYTE_W;
  localparam int AW = lsfp_pkg::ANGLE_W;
  localparam int DW = lsfp_pkg::DIST_W;
  localparam int PW = lsfp_pkg::PROD_W;
  localparam int CW = lsfp_pkg::CNT_W;
  localparam logic [AW:0]   SLOTS    = (AW + 1)'(ANGLE_SLOTS);
  localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

  logic [BW-1:0] held_low_r;
  logic [BW-1:0] total_r;
  logic [BW-1:0] index_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] span_r;
  logic [DW-1:0] dist_r;
  logic          last_r;
  logic [BW-1:0] rem_r;
  logic [PW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic [AW-1:0] out_angle_r;
  logic [DW-1:0] out_dist_r;
  logic          out_last_r;

  logic [AW-1:0] word_deg;
  logic [DW-1:0] raw_dist;
  logic [BW-1:0] divisor;
  logic [BW:0]   trial;
  logic          trial_ge;
  logic [BW-1:0] rem_nxt;
  logic [AW-1:0] quo_sel;
  logic [AW:0]   angle_sum;

  // 16-bit little-endian word shifted right by 7 for the angle, by 2 for the distance
  assign word_deg = {in_data_byte, held_low_r[BW-1]};
  assign raw_dist = {in_data_byte, held_low_r[BW-1:2]};

  assign divisor  = total_r - BW'(1);
  assign trial    = {rem_r, quo_r[PW-1]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign rem_nxt  = trial_ge ? BW'(trial - {1'b0, divisor}) : trial[BW-1:0];

  // a single-sample frame sits at the start angle
  assign quo_sel   = (total_r <= BW'(1)) ? '0 : quo_r[AW-1:0];
  assign angle_sum = {1'b0, start_r} + {1'b0, quo_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      index_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_count) begin
        total_r <= in_data_byte;
        index_r <= '0;
      end
      if (cmd.ld_low) held_low_r <= in_data_byte;
      if (cmd.ld_start) start_r <= word_deg;
      if (cmd.ld_span) span_r <= (word_deg >= start_r) ? word_deg - start_r : start_r - word_deg;
      if (cmd.ld_sample) begin
        dist_r <= (raw_dist < min_dist || raw_dist > max_dist) ? '0 : raw_dist;
        last_r <= ({1'b0, index_r} + (BW + 1)'(1)) >= {1'b0, total_r};
      end
      if (cmd.mul) begin
        quo_r <= PW'(index_r) * PW'(span_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.div_step) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[PW-2:0], trial_ge};
        cnt_r <= cnt_r + CW'(1);
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.emit) begin
        // drop points beyond the last angle slot
        out_valid_r <= angle_sum < SLOTS;
        out_angle_r <= angle_sum[AW-1:0];
        out_dist_r  <= dist_r;
        out_last_r  <= last_r;
        index_r     <= last_r ? '0 : index_r + BW'(1);
      end
    end
  end

  assign st.is_sync_first  = in_data_byte == lsfp_pkg::SYNC_FIRST;
  assign st.is_sync_second = in_data_byte == lsfp_pkg::SYNC_SECOND;
  assign st.total_zero     = total_r == '0;
  assign st.div_last       = cnt_r == DIV_LAST;
  assign st.last           = last_r;
  assign st.out_busy       = out_valid_r;

  assign out_valid         = out_valid_r;
  assign out_angle_deg     = out_angle_r;
  assign out_distance_mm   = out_dist_r;
  assign out_last_in_frame = out_last_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r)
    else $error("emit while output word pending");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_angle_r} < SLOTS))
    else $error("output angle beyond slot range");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (index_r == '0) || (index_r < total_r))
    else $error("sample index past frame count");

  a_div_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (cnt_r == '0) && cmd.div_step)
    else $error("divider not started after multiply");

endmodule

// File: sv/lidar_scan_frame_parser.sv
// Scanner frame parser: top level with configuration registers, state machine
// and datapath. Depends on lsfp_pkg, lsfp_ctrl and lsfp_dp.
`timescale 1ns / 1ps

// Takes one stream byte per word on the in_ channel, finds the 0xAA 0x55 sync
// pair, reads the header (type, sample count, start and end angle, checksum)
// and emits one point per two-byte sample whose interpolated angle is below
// ANGLE_SLOTS. Every sync, header and low sample byte is taken with no stall.
// The high byte of a sample is latched and then stalls the input through the
// index times span multiply, the restoring divider (one quotient bit a cycle
// over the 17-bit product) and the load of the output register, which also
// waits while the previous point still sits there.
// The lower distance limit sits at byte address 0 and the upper one at 4 on
// the cfg_ port.

module lidar_scan_frame_parser #(
  parameter int ANGLE_SLOTS = lsfp_pkg::ANGLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsfp_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsfp_pkg::ANGLE_W-1:0]  out_angle_deg,
  output logic [lsfp_pkg::DIST_W-1:0]   out_distance_mm,
  output logic                          out_last_in_frame,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int DW = lsfp_pkg::DIST_W;

  logic [DW-1:0]     min_dist_r;
  logic [DW-1:0]     max_dist_r;
  logic              cfg_wr;
  lsfp_pkg::cmd_t    cmd;
  lsfp_pkg::status_t st;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= lsfp_pkg::MIN_DIST_RST;
      max_dist_r <= lsfp_pkg::MAX_DIST_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == lsfp_pkg::REG_MIN_DIST) min_dist_r <= cfg_pwdata[DW-1:0];
      else max_dist_r <= cfg_pwdata[DW-1:0];
    end
  end

  assign cfg_prdata = {(32 - DW)'(0),
                       (cfg_paddr[2] == lsfp_pkg::REG_MIN_DIST) ? min_dist_r : max_dist_r};

  lsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lsfp_dp #(
    .ANGLE_SLOTS (ANGLE_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_data_byte),
    .min_dist          (min_dist_r),
    .max_dist          (max_dist_r),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_angle_deg     (out_angle_deg),
    .out_distance_mm   (out_distance_mm),
    .out_last_in_frame (out_last_in_frame)
  );

endmodule

// File: tb/tb_lidar_scan_frame_parser.sv
// Self-checking bench for the scanner frame parser: byte stream in, points out.
// Depends on lsfp_pkg and lidar_scan_frame_parser; a built-in predictor checks every point.
`timescale 1ns / 1ps

module tb_lidar_scan_frame_parser;

  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;

  localparam int BW = lsfp_pkg::BYTE_W;
  localparam int AW = lsfp_pkg::ANGLE_W;
  localparam int DW = lsfp_pkg::DIST_W;

  typedef struct packed {
    logic [AW-1:0] angle;
    logic [DW-1:0] dist_mm;
    logic          last;
  } point_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BW-1:0]     in_data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [AW-1:0]     out_angle_deg;
  logic [DW-1:0]     out_distance_mm;
  logic              out_last_in_frame;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  lidar_scan_frame_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_angle_deg(out_angle_deg),
    .out_distance_mm(out_distance_mm), .out_last_in_frame(out_last_in_frame),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stream bytes waiting to be sent, points the parser still owes us
  logic [BW-1:0]     byte_q[$];
  point_t            points_due[$];
  int                pushed = 0;
  int                mismatches = 0;
  bit                burst_mode = 1'b0;
  bit                hold_req = 1'b0;

  // predictor state
  logic [DW-1:0]     lim_lo = lsfp_pkg::MIN_DIST_RST;
  logic [DW-1:0]     lim_hi = lsfp_pkg::MAX_DIST_RST;
  lsfp_pkg::phase_t  scan_ph = lsfp_pkg::PH_HUNT_A;
  logic [7:0]        n_samples = '0;
  logic [7:0]        smp_idx = '0;
  logic [AW-1:0]     base_deg = '0;
  logic [AW-1:0]     sweep = '0;
  logic [7:0]        lo_byte = '0;

  function automatic void parse_byte(input logic [7:0] b);
    logic [AW-1:0] end_deg;
    int            raw;
    int            d;
    int            ang;
    logic          fin;
    point_t        pt;
    case (scan_ph)
      lsfp_pkg::PH_HUNT_A: begin
        if (b == lsfp_pkg::SYNC_FIRST) scan_ph = lsfp_pkg::PH_HUNT_B;
      end
      lsfp_pkg::PH_HUNT_B: begin
        if (b == lsfp_pkg::SYNC_SECOND) scan_ph = lsfp_pkg::PH_TYPE;
        else if (b != lsfp_pkg::SYNC_FIRST) scan_ph = lsfp_pkg::PH_HUNT_A;
      end
      lsfp_pkg::PH_TYPE: scan_ph = lsfp_pkg::PH_COUNT;
      lsfp_pkg::PH_COUNT: begin
        n_samples = b;
        smp_idx = '0;
        scan_ph = lsfp_pkg::PH_FSA_LO;
      end
      lsfp_pkg::PH_FSA_LO: begin
        lo_byte = b;
        scan_ph = lsfp_pkg::PH_FSA_HI;
      end
      lsfp_pkg::PH_FSA_HI: begin
        base_deg = AW'({b, lo_byte} >> 7);
        scan_ph = lsfp_pkg::PH_LSA_LO;
      end
      lsfp_pkg::PH_LSA_LO: begin
        lo_byte = b;
        scan_ph = lsfp_pkg::PH_LSA_HI;
      end
      lsfp_pkg::PH_LSA_HI: begin
        end_deg = AW'({b, lo_byte} >> 7);
        sweep = (end_deg >= base_deg) ? end_deg - base_deg : base_deg - end_deg;
        scan_ph = lsfp_pkg::PH_CS_LO;
      end
      lsfp_pkg::PH_CS_LO: scan_ph = lsfp_pkg::PH_CS_HI;
      lsfp_pkg::PH_CS_HI: begin
        scan_ph = (n_samples == 0) ? lsfp_pkg::PH_HUNT_A : lsfp_pkg::PH_SMP_LO;
      end
      lsfp_pkg::PH_SMP_LO: begin
        lo_byte = b;
        scan_ph = lsfp_pkg::PH_SMP_HI;
      end
      lsfp_pkg::PH_SMP_HI: begin
        raw = int'({b, lo_byte});
        d = raw >> 2;
        if (d < int'(lim_lo) || d > int'(lim_hi)) d = 0;
        if (n_samples <= 1) ang = int'(base_deg);
        else ang = int'(base_deg) + (int'(smp_idx) * int'(sweep)) / (int'(n_samples) - 1);
        fin = (int'(smp_idx) + 1 >= int'(n_samples));
        if (fin) begin
          scan_ph = lsfp_pkg::PH_HUNT_A;
          smp_idx = '0;
        end else begin
          scan_ph = lsfp_pkg::PH_SMP_LO;
          smp_idx = smp_idx + 8'd1;
        end
        // angles past the last slot vanish, last flag included
        if (ang < lsfp_pkg::ANGLE_SLOTS_DEF) begin
          pt.angle = AW'(ang);
          pt.dist_mm = DW'(d);
          pt.last = fin;
          points_due.push_back(pt);
        end
      end
      default: scan_ph = lsfp_pkg::PH_HUNT_A;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // sample raw word, biased toward the distance limits
  function automatic logic [15:0] pick_raw();
    int d;
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 65535));
      1: d = 0;
      2: d = 16383;
      3: d = int'(lim_lo) - 1;
      4: d = int'(lim_lo);
      5: d = int'(lim_hi);
      6: d = int'(lim_hi) + 1;
      default: d = $urandom_range(lim_lo, lim_hi);
    endcase
    if (d < 0) d = 0;
    if (d > 16383) d = 16383;
    return 16'((d << 2) | $urandom_range(0, 3));
  endfunction

  task automatic put(input logic [7:0] b);
    byte_q.push_back(b);
    pushed++;
  endtask

  task automatic put_sample(input logic [15:0] raw);
    put(raw[7:0]);
    put(raw[15:8]);
  endtask

  task automatic put_header(input int n, input int a_deg, input int b_deg);
    logic [15:0] wa;
    logic [15:0] wb;
    wa = 16'((a_deg << 7) | $urandom_range(0, 127));
    wb = 16'((b_deg << 7) | $urandom_range(0, 127));
    put(lsfp_pkg::SYNC_FIRST);
    put(lsfp_pkg::SYNC_SECOND);
    put(8'($urandom_range(0, 255)));
    put(n[7:0]);
    put(wa[7:0]);
    put(wa[15:8]);
    put(wb[7:0]);
    put(wb[15:8]);
    put(8'($urandom_range(0, 255)));
    put(8'($urandom_range(0, 255)));
  endtask

  task automatic put_frame(input int n, input int a_deg, input int b_deg);
    put_header(n, a_deg, b_deg);
    for (int i = 0; i < n; i++) put_sample(pick_raw());
  endtask

  // mostly well-formed frames, some sync noise and stray bytes
  task automatic put_traffic(input int budget);
    int goal;
    int r;
    int n;
    int top;
    goal = pushed + budget;
    while (pushed < goal) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        r = $urandom_range(0, 9);
        if (r < 6) n = $urandom_range(0, 4);
        else if (r < 9) n = $urandom_range(5, 20);
        else n = $urandom_range(21, 60);
        top = ($urandom_range(0, 3) == 0) ? 511 : 359;
        put_frame(n, $urandom_range(0, top), $urandom_range(0, top));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 2))
            0: put(lsfp_pkg::SYNC_FIRST);
            1: put(lsfp_pkg::SYNC_SECOND);
            default: put(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [DW-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {{(32 - DW){1'b0}}, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == lsfp_pkg::REG_MIN_DIST) lim_lo = val;
    else lim_hi = val;
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input side: note acceptances, feed the predictor
  logic in_took = 1'b0;
  int   in_gap = 0;

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) parse_byte(in_data_byte);
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_data_byte <= byte_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= burst_mode ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stalls plus one long hold on request
  int rx_gap = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!burst_mode && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  point_t due_pt;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (points_due.size() == 0) begin
        $error("unexpected point: angle_deg=%0d distance_mm=%0d last_in_frame=%0d",
               out_angle_deg, out_distance_mm, out_last_in_frame);
        mismatches++;
      end else begin
        due_pt = points_due.pop_front();
        if (out_angle_deg !== due_pt.angle) begin
          $error("angle_deg: expected %0d, got %0d", due_pt.angle, out_angle_deg);
          mismatches++;
        end
        if (out_distance_mm !== due_pt.dist_mm) begin
          $error("distance_mm: expected %0d, got %0d", due_pt.dist_mm, out_distance_mm);
          mismatches++;
        end
        if (out_last_in_frame !== due_pt.last) begin
          $error("last_in_frame: expected %0d, got %0d", due_pt.last, out_last_in_frame);
          mismatches++;
        end
      end
    end
  end

  // end the run if no word moves on either side for too long
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[lidar_scan_frame_parser] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: broken sync, repeated sync byte, single sample, empty frame,
    // and a final sample whose angle falls past the last slot
    put(lsfp_pkg::SYNC_FIRST);
    put(8'h13);
    put(lsfp_pkg::SYNC_FIRST);
    put_header(1, 359, 359);
    put_sample(16'hFFFF);
    put_header(0, 0, 511);
    put_header(2, 0, 511);
    put_sample(16'h0000);
    put_sample(16'h00C8);
    put_traffic(20);
    drain();

    // widest window, back-to-back words, one long frame over the widest span
    write_reg(lsfp_pkg::REG_MIN_DIST, 14'd0);
    write_reg(lsfp_pkg::REG_MAX_DIST, 14'd16383);
    burst_mode = 1'b1;
    put_frame(130, 0, 511);
    put_traffic(20);
    drain();
    burst_mode = 1'b0;

    // inverted limits zero every distance
    write_reg(lsfp_pkg::REG_MIN_DIST, 14'd16383);
    write_reg(lsfp_pkg::REG_MAX_DIST, 14'd0);
    put_traffic(40);
    drain();

    // hold the receiver while frames keep coming
    write_reg(lsfp_pkg::REG_MIN_DIST, 14'd1000);
    write_reg(lsfp_pkg::REG_MAX_DIST, 14'd1200);
    hold_req = 1'b1;
    repeat (2) put_frame(16, $urandom_range(0, 359), $urandom_range(0, 359));
    drain();

    write_reg(lsfp_pkg::REG_MAX_DIST, 14'd16383);
    put_traffic(30);
    drain();

    repeat (2) begin
      write_reg(lsfp_pkg::REG_MIN_DIST, DW'($urandom_range(0, 2000)));
      write_reg(lsfp_pkg::REG_MAX_DIST, DW'($urandom_range(1000, 16383)));
      put_traffic(20);
      drain();
    end

    if (mismatches == 0) begin
      $display("[lidar_scan_frame_parser] OK");
    end else begin
      $display("[lidar_scan_frame_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: lidar_scan_frame_parser.f
sv/lsfp_pkg.sv
sv/lsfp_ctrl.sv
sv/lsfp_dp.sv
sv/lidar_scan_frame_parser.sv
tb/tb_lidar_scan_frame_parser.sv
